// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the handle allocator RTL.
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every edge
`define THA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same-cycle implication
`define THA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define THA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tha_pkg.sv
// ----------------------------------------------------------------------------
// tha_pkg
// Shared constants, types and the LFSR step for the handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tha_pkg;

  localparam int NUM_ENTRIES = 256;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam int HANDLE_W    = 32;
  localparam int MAX_DRAWS   = 64;
  localparam int DRAW_W      = $clog2(MAX_DRAWS);
  localparam int MOD_CNT_W   = $clog2(HANDLE_W);

  localparam logic [HANDLE_W-1:0] LFSR_SEED = 32'hACE1_ACE1;
  localparam logic [HANDLE_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  typedef logic [HANDLE_W-1:0] word_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // one slot of the tag store
  typedef struct packed {
    logic  used;
    word_t tag;
  } slot_t;

  // Galois LFSR, one step
  function automatic word_t lfsr_step(input word_t s);
    word_t n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tha_ram.sv
// ----------------------------------------------------------------------------
// tha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tha_mod.sv
// ----------------------------------------------------------------------------
// tha_mod
// Bit-serial remainder unit: one restoring step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tha_mod (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tha_pkg::word_t dividend,
  input  wire tha_pkg::word_t divisor,
  output logic               done,
  output tha_pkg::word_t     rem
);

  import tha_pkg::*;

  `include "assert_macros.svh"

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  word_t                rem_r, rem_nxt;
  word_t                dvd_r, dvd_nxt;
  logic [HANDLE_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    trial    = {rem_r, dvd_r[HANDLE_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = HANDLE_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[HANDLE_W-1:0];
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
      if (cnt_r == MOD_CNT_W'(HANDLE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  `THA_ASSERT_IMP(a_start_idle, start, !busy_r, "remainder unit restarted while busy")
  `THA_ASSERT_NXT(a_done_pulse, done_r, !done_r && !busy_r, "done is not a single pulse")

endmodule

`default_nettype wire

// File: rtl/tagged_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// tagged_handle_allocator_unit: generational handle table, 256 slots
// Release/lookup pass S_TAG and S_FIN; allocate passes S_RING and S_TAG, then per draw
// S_DRAW, S_EVAL (plus S_MOD when reduced) and S_TEST, then S_FIN. One word at a time.
// The random-retry loop and the 1-bit/cycle remainder set how long an allocate takes.
// Reset: synchronous rst_n low; tag valid bits and ring wrap flag clear at once, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_handle_allocator_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [tha_pkg::CMD_W-1:0] in_cmd,
  input  wire tha_pkg::word_t          in_handle,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output tha_pkg::word_t               out_result_handle,
  output logic [7:0]                   out_slot_index,
  output logic                         out_ok,
  output tha_pkg::cnt_t                out_live_count,
  // configuration
  input  wire logic                    cfg_we,
  input  wire tha_pkg::word_t          cfg_wdata
);

  import tha_pkg::*;

  `include "assert_macros.svh"

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] S_RING = 3'd1;  // free ring read data back
  localparam logic [2:0] S_TAG  = 3'd2;  // tag store read data back
  localparam logic [2:0] S_DRAW = 3'd3;  // step the LFSR
  localparam logic [2:0] S_EVAL = 3'd4;  // decide whether the draw needs reducing
  localparam logic [2:0] S_MOD  = 3'd5;  // wait on the remainder unit
  localparam logic [2:0] S_TEST = 3'd6;  // accept or reject the candidate
  localparam logic [2:0] S_FIN  = 3'd7;  // write back and present the result

  logic [2:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  word_t             handle_r, handle_nxt;
  idx_t              idx_r, idx_nxt;
  word_t             old_r, old_nxt;
  word_t             cand_r, cand_nxt;
  word_t             lfsr_r, lfsr_nxt;
  logic [DRAW_W-1:0] draws_r, draws_nxt;
  logic              ok_r, ok_nxt;
  word_t             max_id_r, max_id_nxt;
  idx_t              head_r, head_nxt;
  idx_t              tail_r, tail_nxt;
  logic              wrap_r, wrap_nxt;   // tail has gone all the way round once
  cnt_t              live_r, live_nxt;
  logic [NUM_ENTRIES-1:0] tag_vld_r, tag_vld_nxt;

  logic              out_valid_r, out_valid_nxt;
  word_t             out_handle_r, out_handle_nxt;
  idx_t              out_slot_r, out_slot_nxt;
  logic              out_ok_r, out_ok_nxt;
  cnt_t              out_live_r, out_live_nxt;

  // memory ports
  logic  tag_we, tag_re;
  idx_t  tag_waddr, tag_raddr;
  slot_t tag_wdata, tag_rdata, tag_ent;
  logic  ring_we, ring_re;
  idx_t  ring_waddr, ring_raddr, ring_wdata, ring_rdata;

  // remainder unit
  logic  mod_start, mod_done;
  word_t mod_rem, mod_div;

  logic  in_acc, out_free, ring_written;
  word_t fresh;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign mod_div  = max_id_r + HANDLE_W'(1);
  // ring position at head has been rewritten since reset?
  assign ring_written = wrap_r || (head_r < tail_r);
  // candidate handle: random upper part, slot index below
  assign fresh = {cand_r[HANDLE_W-1:IDX_W], idx_r};

  // an entry never written reads as its reset value: free, tag = index
  always_comb begin
    if (tag_vld_r[idx_r]) begin
      tag_ent = tag_rdata;
    end else begin
      tag_ent.used = 1'b0;
      tag_ent.tag  = HANDLE_W'(idx_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    handle_nxt     = handle_r;
    idx_nxt        = idx_r;
    old_nxt        = old_r;
    cand_nxt       = cand_r;
    lfsr_nxt       = lfsr_r;
    draws_nxt      = draws_r;
    ok_nxt         = ok_r;
    max_id_nxt     = max_id_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    wrap_nxt       = wrap_r;
    live_nxt       = live_r;
    tag_vld_nxt    = tag_vld_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_handle_nxt = out_handle_r;
    out_slot_nxt   = out_slot_r;
    out_ok_nxt     = out_ok_r;
    out_live_nxt   = out_live_r;

    tag_we     = 1'b0;
    tag_waddr  = idx_r;
    tag_wdata  = tag_ent;
    tag_re     = 1'b0;
    tag_raddr  = idx_r;
    ring_we    = 1'b0;
    ring_waddr = tail_r;
    ring_wdata = idx_r;
    ring_re    = 1'b0;
    ring_raddr = head_r;
    mod_start  = 1'b0;

    // values below the pool size are refused
    if (cfg_we && (cfg_wdata >= HANDLE_W'(NUM_ENTRIES))) begin
      max_id_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_cmd;
          handle_nxt = in_handle;
          ok_nxt     = 1'b0;
          case (in_cmd)
            CMD_ALLOC: begin
              if (live_r == CNT_W'(NUM_ENTRIES)) begin
                state_nxt = S_FIN;            // pool exhausted
              end else begin
                ring_re   = 1'b1;
                state_nxt = S_RING;
              end
            end
            CMD_RELEASE, CMD_LOOKUP: begin
              idx_nxt   = in_handle[IDX_W-1:0];
              tag_re    = 1'b1;
              tag_raddr = in_handle[IDX_W-1:0];
              state_nxt = S_TAG;
            end
            default: begin
              state_nxt = S_FIN;              // unknown command: no effect
            end
          endcase
        end
      end
      S_RING: begin
        idx_nxt   = ring_written ? ring_rdata : head_r;
        tag_re    = 1'b1;
        tag_raddr = idx_nxt;
        state_nxt = S_TAG;
      end
      S_TAG: begin
        if (cmd_r == CMD_ALLOC) begin
          old_nxt   = tag_ent.tag;
          draws_nxt = '0;
          state_nxt = S_DRAW;
        end else begin
          ok_nxt    = tag_ent.used && (tag_ent.tag == handle_r);
          state_nxt = S_FIN;
        end
      end
      S_DRAW: begin
        lfsr_nxt  = lfsr_step(lfsr_r);
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // draw already below max_id+1 needs no reduction
        if (!(&max_id_r) && (lfsr_r > max_id_r)) begin
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end else begin
          cand_nxt  = lfsr_r;
          state_nxt = S_TEST;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          cand_nxt  = mod_rem;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if ((|cand_r[HANDLE_W-1:IDX_W]) && (fresh != old_r)) begin
          ok_nxt    = 1'b1;
          state_nxt = S_FIN;
        end else if (draws_r == DRAW_W'(MAX_DRAWS - 1)) begin
          state_nxt = S_FIN;                  // out of draws; LFSR keeps its state
        end else begin
          draws_nxt = draws_r + DRAW_W'(1);
          state_nxt = S_DRAW;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = ok_r;
          out_handle_nxt = '0;
          out_slot_nxt   = '0;
          out_live_nxt   = live_r;
          case (cmd_r)
            CMD_ALLOC: begin
              if (ok_r) begin
                tag_we          = 1'b1;
                tag_wdata.used  = 1'b1;
                tag_wdata.tag   = fresh;
                tag_vld_nxt[idx_r] = 1'b1;
                head_nxt        = head_r + IDX_W'(1);
                live_nxt        = live_r + CNT_W'(1);
                out_live_nxt    = live_nxt;
                out_handle_nxt  = fresh;
                out_slot_nxt    = idx_r;
              end
            end
            CMD_RELEASE: begin
              out_slot_nxt = idx_r;
              if (ok_r) begin
                tag_we         = 1'b1;
                tag_wdata.used = 1'b0;
                tag_wdata.tag  = handle_r;
                tag_vld_nxt[idx_r] = 1'b1;
                ring_we        = 1'b1;
                tail_nxt       = tail_r + IDX_W'(1);
                if (&tail_r) begin
                  wrap_nxt = 1'b1;
                end
                live_nxt       = live_r - CNT_W'(1);
                out_live_nxt   = live_nxt;
              end
            end
            CMD_LOOKUP: begin
              out_slot_nxt = idx_r;
            end
            default: begin
              out_slot_nxt = '0;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lfsr_r      <= LFSR_SEED;
      max_id_r    <= '1;
      head_r      <= '0;
      tail_r      <= '0;
      wrap_r      <= 1'b0;
      live_r      <= '0;
      tag_vld_r   <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lfsr_r      <= lfsr_nxt;
      max_id_r    <= max_id_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      wrap_r      <= wrap_nxt;
      live_r      <= live_nxt;
      tag_vld_r   <= tag_vld_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
    end
    cmd_r        <= cmd_nxt;
    handle_r     <= handle_nxt;
    idx_r        <= idx_nxt;
    old_r        <= old_nxt;
    cand_r       <= cand_nxt;
    draws_r      <= draws_nxt;
    out_handle_r <= out_handle_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ok_r     <= out_ok_nxt;
    out_live_r   <= out_live_nxt;
  end

  // tag store: {in use, last handle} per slot
  tha_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (NUM_ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // free ring of slot indices
  tha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_ENTRIES)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  tha_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (lfsr_r),
    .divisor  (mod_div),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_handle = out_handle_r;
  assign out_slot_index    = 8'(out_slot_r);
  assign out_ok            = out_ok_r;
  assign out_live_count    = out_live_r;

  `THA_ASSERT(a_live_bound, live_r <= CNT_W'(NUM_ENTRIES), "live count above pool size")
  `THA_ASSERT_IMP(a_alloc_slot_free, (state_r == S_TAG) && (cmd_r == CMD_ALLOC), !tag_ent.used, "free ring handed out a slot in use")
  `THA_ASSERT_IMP(a_out_from_fin, $rose(out_valid_r), $past(state_r == S_FIN), "result word raised outside write-back")
  `THA_ASSERT_IMP(a_release_live, (state_r == S_FIN) && (cmd_r == CMD_RELEASE) && ok_r, live_r != '0, "release with no live slot")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for tagged_handle_allocator_unit
// Drives allocate / release / lookup / unknown words through the valid-ready
// input channel and compares every result word field by field against a
// behavioural copy of the handle table (tags, free ring, LFSR, max_id).
// A directed table comes first, then randomised phases under several max_id
// settings, including a full-pool phase and the smallest accepted max_id.
// ----------------------------------------------------------------------------
module tb_top;
  import tha_pkg::*;

  // the one command code the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // worst allocate is 64 reduced draws; leave lots of room
  localparam int unsigned WATCHDOG_LIMIT = 12000;

  // one result word as the block reports it
  typedef struct packed {
    word_t       handle;
    logic [7:0]  slot;
    logic        ok;
    cnt_t        live;
  } result_t;

  // where a directed row takes its handle from
  typedef enum logic [1:0] {
    SRC_LIT,       // handle typed into the row
    SRC_LAST,      // most recent successful allocate
    SRC_LAST_BAD   // same, with the top tag bit flipped
  } hsrc_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    hsrc_t            src;
    word_t            handle;
    logic             typed;   // ans below is the expectation, not the predictor
    result_t          ans;
  } step_row_t;

  typedef enum logic [1:0] {RDY_OPEN, RDY_PATTERN, RDY_COIN, RDY_STARVE} rdy_mode_t;

  // Directed words. Only the rows straight after reset carry a typed answer;
  // everything else goes through the predictor.
  localparam step_row_t DIRECTED_STEPS [19] = '{
    // invalid handle 0 is never live, release of it does nothing
    '{CMD_LOOKUP,  SRC_LIT, 32'h0000_0000, 1'b1, '{32'h0, 8'h00, 1'b0, 9'd0}},
    '{CMD_RELEASE, SRC_LIT, 32'h0000_0000, 1'b1, '{32'h0, 8'h00, 1'b0, 9'd0}},
    // all-ones handle: slot index reported even though nothing matches
    '{CMD_LOOKUP,  SRC_LIT, 32'hFFFF_FFFF, 1'b1, '{32'h0, 8'hFF, 1'b0, 9'd0}},
    '{CMD_RELEASE, SRC_LIT, 32'hFFFF_FFFF, 1'b1, '{32'h0, 8'hFF, 1'b0, 9'd0}},
    // unknown command answers all zero
    '{CMD_UNKNOWN, SRC_LIT, 32'hFFFF_FFFF, 1'b1, '{32'h0, 8'h00, 1'b0, 9'd0}},
    // reset tag equals the index, but the slot is free
    '{CMD_LOOKUP,  SRC_LIT, 32'h0000_0005, 1'b1, '{32'h0, 8'h05, 1'b0, 9'd0}},
    '{CMD_ALLOC,   SRC_LIT, 32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_LOOKUP,  SRC_LAST, 32'h0, 1'b0, '0},
    '{CMD_LOOKUP,  SRC_LAST_BAD, 32'h0, 1'b0, '0},   // tag mismatch
    '{CMD_RELEASE, SRC_LAST_BAD, 32'h0, 1'b0, '0},   // tag mismatch
    '{CMD_RELEASE, SRC_LAST, 32'h0, 1'b0, '0},
    '{CMD_RELEASE, SRC_LAST, 32'h0, 1'b0, '0},       // slot already free
    '{CMD_LOOKUP,  SRC_LAST, 32'h0, 1'b0, '0},
    '{CMD_ALLOC,   SRC_LIT, 32'h0000_0000, 1'b0, '0},
    '{CMD_ALLOC,   SRC_LIT, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_UNKNOWN, SRC_LAST, 32'h0, 1'b0, '0},
    '{CMD_LOOKUP,  SRC_LAST, 32'h0, 1'b0, '0},
    '{CMD_RELEASE, SRC_LAST, 32'h0, 1'b0, '0},
    '{CMD_ALLOC,   SRC_LIT, 32'h5555_5555, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd = '0;
  word_t            in_handle = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  word_t            out_result_handle;
  logic [7:0]       out_slot_index;
  logic             out_ok;
  cnt_t             out_live_count;
  logic             cfg_we = 1'b0;
  word_t            cfg_wdata = '0;

  always #4 clk = ~clk;

  tagged_handle_allocator_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_handle         (in_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_handle (out_result_handle),
    .out_slot_index    (out_slot_index),
    .out_ok            (out_ok),
    .out_live_count    (out_live_count),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Handle table model
  // Mirrors the block's state; stepped once per accepted input word, in
  // acceptance order, from the sending process.
  // --------------------------------------------------------------------------
  word_t   tag_store [NUM_ENTRIES];
  logic    slot_busy [NUM_ENTRIES];
  idx_t    free_fifo [NUM_ENTRIES];
  idx_t    fifo_rd;
  idx_t    fifo_wr;
  cnt_t    free_slots;
  word_t   lfsr_q;
  word_t   handle_limit;   // max_id
  word_t   last_handle;    // most recent successful allocate

  result_t pending_answers [$];
  int      mismatch_count = 0;
  int      burst_left = 0;

  function automatic void handle_table_reset();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tag_store[i] = word_t'(i);
      slot_busy[i] = 1'b0;
      free_fifo[i] = idx_t'(i);
    end
    fifo_rd      = '0;
    fifo_wr      = '0;
    free_slots   = cnt_t'(NUM_ENTRIES);
    lfsr_q       = LFSR_SEED;
    handle_limit = '1;
    last_handle  = '0;
  endfunction

  // writes below the pool size are dropped by the block
  function automatic void handle_limit_write(input word_t v);
    if (v >= word_t'(NUM_ENTRIES)) begin
      handle_limit = v;
    end
  endfunction

  function automatic result_t handle_table_step(input logic [CMD_W-1:0] c, input word_t h);
    result_t     r;
    idx_t        idx;
    logic [63:0] draw;
    word_t       fresh;
    logic        found;
    r     = '0;
    found = 1'b0;
    fresh = '0;
    idx   = h[IDX_W-1:0];
    case (c)
      CMD_ALLOC: begin
        if (free_slots != 0) begin
          idx = free_fifo[fifo_rd];
          // retry loop: tag part must be nonzero and differ from the old handle
          for (int n = 0; n < MAX_DRAWS && !found; n++) begin
            lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : word_t'(0));
            draw   = {32'd0, lfsr_q};
            if (handle_limit != '1) begin
              draw = draw % ({32'd0, handle_limit} + 64'd1);
            end
            fresh = draw[31:0] & ~word_t'(NUM_ENTRIES - 1);
            if (fresh != '0) begin
              fresh = fresh | word_t'(idx);
              found = (fresh != tag_store[idx]);
            end
          end
          // no usable draw leaves the slot at the head, LFSR stays advanced
          if (found) begin
            fifo_rd        = fifo_rd + 1'b1;
            free_slots     = free_slots - 1'b1;
            tag_store[idx] = fresh;
            slot_busy[idx] = 1'b1;
            last_handle    = fresh;
            r.handle       = fresh;
            r.slot         = 8'(idx);
            r.ok           = 1'b1;
          end
        end
      end
      CMD_RELEASE: begin
        r.slot = 8'(idx);
        if (tag_store[idx] == h && slot_busy[idx]) begin
          slot_busy[idx]    = 1'b0;
          free_fifo[fifo_wr] = idx;
          fifo_wr           = fifo_wr + 1'b1;
          free_slots        = free_slots + 1'b1;
          r.ok              = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        r.slot = 8'(idx);
        r.ok   = (tag_store[idx] == h) && slot_busy[idx];
      end
      default: ;
    endcase
    r.live = cnt_t'(NUM_ENTRIES) - free_slots;
    return r;
  endfunction

  // random slot that is in use (or free); -1 when there is none
  function automatic int pick_slot(input logic want_busy);
    int start;
    start = $urandom_range(0, NUM_ENTRIES - 1);
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (slot_busy[(start + k) % NUM_ENTRIES] == want_busy) begin
        return (start + k) % NUM_ENTRIES;
      end
    end
    return -1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of words with random gaps. Payload changes only at the
  // falling edge; acceptance is seen at the rising edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [CMD_W-1:0] c, input word_t h,
                           input logic typed, input result_t typed_ans);
    int      gap;
    result_t ans;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_cmd    <= c;
    in_handle <= h;
    do @(posedge clk); while (!in_ready);
    ans = handle_table_step(c, h);
    pending_answers.push_back(typed ? typed_ans : ans);
  endtask

  // drop valid so the old word is not taken again while we drain
  task automatic pause_input();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // max_id is written only with the block drained
  task automatic write_max_id(input word_t v);
    while (pending_answers.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    handle_limit_write(v);
  endtask

  // Mixed traffic. Releases and lookups mostly aim at live handles so the
  // success paths get exercised; the rest are stale, corrupted or random.
  task automatic random_mix(input int count, input int alloc_pct);
    int               r;
    int               s;
    int               pick;
    logic [CMD_W-1:0] c;
    word_t            h;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      h = $urandom;
      if (r < alloc_pct) begin
        c = CMD_ALLOC;
      end else if (r >= 96) begin
        c = CMD_UNKNOWN;
      end else begin
        c    = $urandom_range(0, 1) ? CMD_RELEASE : CMD_LOOKUP;
        pick = $urandom_range(0, 9);
        if (pick == 6) begin
          s = pick_slot(1'b0);          // stale handle of a freed slot
        end else if (pick == 9) begin
          s = -1;                       // fully random handle
        end else begin
          s = pick_slot(1'b1);
        end
        if (s >= 0) begin
          h = tag_store[s];
        end
        if (pick == 7 || pick == 8) begin
          h = h ^ (word_t'(1) << $urandom_range(0, 31));
        end
      end
      send_word(c, h, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready follows a randomly drawn mode, redrawn when its span runs out -
  // always open, a rotating bit pattern, a coin toss, or mostly stalled.
  // --------------------------------------------------------------------------
  int unsigned ready_span = 0;
  rdy_mode_t   ready_mode = RDY_OPEN;
  logic [15:0] ready_pat  = 16'b1101_1100_1011_0110;

  always @(negedge clk) begin
    ready_pat <= {ready_pat[14:0], ready_pat[15]};
    if (ready_span == 0) begin
      ready_mode <= rdy_mode_t'($urandom_range(0, 3));
      ready_span <= $urandom_range(16, 160);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      RDY_OPEN:    out_ready <= 1'b1;
      RDY_PATTERN: out_ready <= ready_pat[0];
      RDY_COIN:    out_ready <= ($urandom_range(0, 3) != 0);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  result_t seen_ans;
  result_t want_ans;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_ans = '{out_result_handle, out_slot_index, out_ok, out_live_count};
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result word", seen_ans.handle, 32'h0);
      end else begin
        want_ans = pending_answers.pop_front();
        if (seen_ans.handle != want_ans.handle)
          report_mismatch("result_handle", seen_ans.handle, want_ans.handle);
        if (seen_ans.slot != want_ans.slot)
          report_mismatch("slot_index", 32'(seen_ans.slot), 32'(want_ans.slot));
        if (seen_ans.ok != want_ans.ok)
          report_mismatch("ok", 32'(seen_ans.ok), 32'(want_ans.ok));
        if (seen_ans.live != want_ans.live)
          report_mismatch("live_count", 32'(seen_ans.live), 32'(want_ans.live));
      end
    end
  end

  // watchdog: too long without any word moving on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tagged_handle_allocator_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    step_row_t row;
    word_t     h;
    word_t     v;
    int        tries;

    handle_table_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows, max_id at its reset value (no reduction)
    for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
      row = DIRECTED_STEPS[i];
      case (row.src)
        SRC_LAST:     h = last_handle;
        SRC_LAST_BAD: h = last_handle ^ 32'h8000_0000;
        default:      h = row.handle;
      endcase
      send_word(row.cmd, h, row.typed, row.ans);
    end
    random_mix(160, 40);
    pause_input();

    // both writes fall below the pool size and must be dropped
    write_max_id(32'h0000_0000);
    write_max_id(32'h0000_00FF);
    random_mix(40, 40);
    pause_input();

    // smallest accepted max_id: almost every draw reduces to a zero tag, and
    // a slot whose last handle was drawn here can never get a fresh handle
    write_max_id(32'h0000_0100);
    random_mix(30, 25);
    pause_input();

    // largest max_id that still reduces
    write_max_id(32'hFFFF_FFFE);
    random_mix(110, 40);
    pause_input();

    write_max_id(word_t'($urandom_range(256, 65535)));
    random_mix(90, 40);
    pause_input();

    // back to no reduction; fill the pool, then knock on it while exhausted
    write_max_id(32'hFFFF_FFFF);
    tries = 0;
    while (free_slots != 0 && tries < 600) begin
      send_word(CMD_ALLOC, $urandom, 1'b0, '0);
      tries++;
    end
    repeat (5) send_word(CMD_ALLOC, $urandom, 1'b0, '0);
    random_mix(120, 20);
    pause_input();

    v = $urandom;
    if (v < word_t'(NUM_ENTRIES)) begin
      v = v | word_t'(NUM_ENTRIES);
    end
    write_max_id(v);
    random_mix(80, 40);
    pause_input();

    // drain, then let the pipeline settle
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tagged_handle_allocator_unit regression: pass");
    end else begin
      $display("tagged_handle_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/tha_pkg.sv
rtl/tha_ram.sv
rtl/tha_mod.sv
rtl/tagged_handle_allocator_unit.sv
bench/tb_top.sv
